// ===== sv/isa_pkg.sv =====
`default_nettype none

package isa_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned DIV_CNT_W       = $clog2(DATA_W + 1);

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_PEEK = 3'd1,
    CMD_POP  = 3'd2,
    CMD_SUB  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_MUL  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PEEK_EMPTY = 3'd1,
    ST_POP_EMPTY  = 3'd2,
    ST_SUB_SHORT  = 3'd3,
    ST_DIV_SHORT  = 3'd4,
    ST_DIV_ZERO   = 3'd5,
    ST_MUL_SHORT  = 3'd6,
    ST_PUSH_FULL  = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP,
    OP_SUB,
    OP_MUL_START,
    OP_MUL_COMMIT,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_DIV_COMMIT
  } dp_op_e;

  typedef struct packed {
    logic    load_in;
    logic    out_load;
    logic    set_status;
    status_e status;
    dp_op_e  op;
  } dp_ctl_t;

  typedef struct packed {
    logic empty;
    logic short_stack;
    logic full;
    logic top_zero;
    logic div_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/integer_stack_alu.sv =====
`default_nettype none

// Stack machine over signed 32-bit integers: one command in, one result out.
// Input channel (in_valid_i/in_ready_o) carries command_i and push_value_i;
// output channel (out_valid_o/out_ready_i) carries top_value_o, top_valid_o
// and status_o. A transfer happens when valid and ready are both high.
// Push, peek, pop and subtract pass through the execute and output states;
// multiply adds a state for its registered product, and divide runs a
// 32-step restoring divider, one quotient bit per cycle, plus a sign fix.
// Each item also waits for the registered stack memory read of the element
// under the top, so a new item is never taken before the last is done.
// A finished result sits in the output register; the next item is taken in
// the same cycle the result is loaded there. If the receiver stalls, the
// result holds and the block stops taking items once its next result is due.
// Reset empties the stack and clears out_valid_o; memory contents are not
// cleared, since only entries below the element count are ever used.

module integer_stack_alu #(
  parameter int unsigned STACK_DEPTH = isa_pkg::STACK_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic        [2:0]  command_i,
  input  wire logic signed [31:0] push_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed      [31:0] top_value_o,
  output logic                    top_valid_o,
  output logic             [2:0]  status_o
);

  isa_pkg::dp_ctl_t ctl;
  isa_pkg::dp_sts_t sts;

  isa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  isa_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .push_value_i (push_value_i),
    .top_value_o  (top_value_o),
    .top_valid_o  (top_valid_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire

// ===== sv/isa_dp.sv =====
`default_nettype none

module isa_dp #(
  parameter int unsigned STACK_DEPTH = isa_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire isa_pkg::dp_ctl_t             ctl_i,
  output isa_pkg::dp_sts_t                  sts_o,
  input  wire logic [isa_pkg::DATA_W-1:0]   push_value_i,
  output logic      [isa_pkg::DATA_W-1:0]   top_value_o,
  output logic                              top_valid_o,
  output logic      [2:0]                   status_o
);

  localparam int unsigned DW = isa_pkg::DATA_W;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned NW = isa_pkg::DIV_CNT_W;

  // Top of stack lives in top_q; the memory holds the elements below it.
  logic [DW-1:0] mem [STACK_DEPTH];

  logic [CW-1:0] count_q, count_d;
  logic [DW-1:0] top_q, val_q, rd_q, mul_q;
  logic [DW-1:0] num_q, den_q, rem_q;
  logic          qneg_q;
  logic [NW-1:0] div_cnt_q;
  logic [2:0]    status_q;
  logic [DW-1:0] top_out_q;
  logic          top_valid_q;
  logic [2:0]    status_out_q;

  logic [CW-1:0] cnt_m1, cnt_m2;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [DW-1:0] abs_rd, abs_top, quo_fix;
  logic [DW:0]   rem_sh, diff;
  logic [2*DW-1:0] prod;

  assign cnt_m1  = count_q - CW'(1);
  assign cnt_m2  = count_q - CW'(2);
  assign rd_addr = cnt_m2[AW-1:0];
  assign wr_addr = cnt_m1[AW-1:0];
  assign wr_en   = (ctl_i.op == isa_pkg::OP_PUSH) && (count_q != '0);

  assign abs_rd  = rd_q[DW-1]  ? (~rd_q + DW'(1))  : rd_q;
  assign abs_top = top_q[DW-1] ? (~top_q + DW'(1)) : top_q;
  assign quo_fix = qneg_q ? (~num_q + DW'(1)) : num_q;
  assign rem_sh  = {rem_q, num_q[DW-1]};
  assign diff    = rem_sh - {1'b0, den_q};
  assign prod    = rd_q * top_q;

  assign sts_o.empty       = (count_q == '0);
  assign sts_o.short_stack = (count_q < CW'(2));
  assign sts_o.full        = (count_q == CW'(STACK_DEPTH));
  assign sts_o.top_zero    = (top_q == '0);
  assign sts_o.div_done    = (div_cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= top_q;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    count_d = count_q;
    case (ctl_i.op)
      isa_pkg::OP_PUSH: count_d = count_q + CW'(1);
      isa_pkg::OP_POP, isa_pkg::OP_SUB, isa_pkg::OP_MUL_COMMIT,
      isa_pkg::OP_DIV_COMMIT: count_d = cnt_m1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      val_q <= push_value_i;
    end
    if (ctl_i.set_status) begin
      status_q <= ctl_i.status;
    end
    if (ctl_i.out_load) begin
      top_out_q    <= (count_q != '0) ? top_q : '0;
      top_valid_q  <= (count_q != '0);
      status_out_q <= status_q;
    end
    case (ctl_i.op)
      isa_pkg::OP_PUSH:       top_q <= val_q;
      isa_pkg::OP_POP:        top_q <= rd_q;
      isa_pkg::OP_SUB:        top_q <= rd_q - top_q;
      isa_pkg::OP_MUL_START:  mul_q <= prod[DW-1:0];
      isa_pkg::OP_MUL_COMMIT: top_q <= mul_q;
      isa_pkg::OP_DIV_START: begin
        num_q     <= abs_rd;
        den_q     <= abs_top;
        rem_q     <= '0;
        qneg_q    <= rd_q[DW-1] ^ top_q[DW-1];
        div_cnt_q <= NW'(DW);
      end
      isa_pkg::OP_DIV_STEP: begin
        // restoring step: shift in one dividend bit, keep difference if nonnegative
        div_cnt_q <= div_cnt_q - NW'(1);
        if (!diff[DW]) begin
          rem_q <= diff[DW-1:0];
          num_q <= {num_q[DW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[DW-1:0];
          num_q <= {num_q[DW-2:0], 1'b0};
        end
      end
      isa_pkg::OP_DIV_COMMIT: top_q <= quo_fix;
      default: ;
    endcase
  end

  assign top_value_o = top_out_q;
  assign top_valid_o = top_valid_q;
  assign status_o    = status_out_q;

endmodule

`default_nettype wire

// ===== sv/isa_ctrl.sv =====
`default_nettype none

module isa_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [2:0]       command_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output isa_pkg::dp_ctl_t      ctl_o,
  input  wire isa_pkg::dp_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_OUT
  } state_e;

  state_e            state_q, state_d;
  isa_pkg::cmd_e     cmd_q, cmd_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d          = state_q;
    cmd_d            = cmd_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    in_ready_o       = 1'b0;
    ctl_o.load_in    = 1'b0;
    ctl_o.out_load   = 1'b0;
    ctl_o.set_status = 1'b0;
    ctl_o.status     = isa_pkg::ST_OK;
    ctl_o.op         = isa_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load_in = 1'b1;
          cmd_d         = isa_pkg::cmd_e'(command_i);
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl_o.set_status = 1'b1;
        state_d          = S_OUT;
        unique case (cmd_q)
          isa_pkg::CMD_PUSH: begin
            if (sts_i.full) ctl_o.status = isa_pkg::ST_PUSH_FULL;
            else            ctl_o.op     = isa_pkg::OP_PUSH;
          end
          isa_pkg::CMD_PEEK: begin
            if (sts_i.empty) ctl_o.status = isa_pkg::ST_PEEK_EMPTY;
          end
          isa_pkg::CMD_POP: begin
            if (sts_i.empty) ctl_o.status = isa_pkg::ST_POP_EMPTY;
            else             ctl_o.op     = isa_pkg::OP_POP;
          end
          isa_pkg::CMD_SUB: begin
            if (sts_i.short_stack) ctl_o.status = isa_pkg::ST_SUB_SHORT;
            else                   ctl_o.op     = isa_pkg::OP_SUB;
          end
          isa_pkg::CMD_DIV: begin
            // short stack takes precedence over a zero divisor
            if (sts_i.short_stack) begin
              ctl_o.status = isa_pkg::ST_DIV_SHORT;
            end else if (sts_i.top_zero) begin
              ctl_o.status = isa_pkg::ST_DIV_ZERO;
            end else begin
              ctl_o.op = isa_pkg::OP_DIV_START;
              state_d  = S_DIV;
            end
          end
          isa_pkg::CMD_MUL: begin
            if (sts_i.short_stack) begin
              ctl_o.status = isa_pkg::ST_MUL_SHORT;
            end else begin
              ctl_o.op = isa_pkg::OP_MUL_START;
              state_d  = S_MUL;
            end
          end
          default: ;
        endcase
      end
      S_MUL: begin
        ctl_o.op = isa_pkg::OP_MUL_COMMIT;
        state_d  = S_OUT;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          ctl_o.op = isa_pkg::OP_DIV_COMMIT;
          state_d  = S_OUT;
        end else begin
          ctl_o.op = isa_pkg::OP_DIV_STEP;
        end
      end
      S_OUT: begin
        // once the output is free, hand the result to the output register and take the next item at once
        if (out_free) begin
          ctl_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          in_ready_o     = 1'b1;
          if (in_valid_i) begin
            ctl_o.load_in = 1'b1;
            cmd_d         = isa_pkg::cmd_e'(command_i);
            state_d       = S_EXEC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= isa_pkg::CMD_PUSH;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/isa_checker.sv =====
`default_nettype none

module isa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] top_value_o,
  input wire logic        top_valid_o,
  input wire logic [2:0]  status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(top_value_o) && $stable(top_valid_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !top_valid_o |-> top_value_o == 32'd0)
    else $error("empty stack reports nonzero top");

  a_empty_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == isa_pkg::ST_PEEK_EMPTY ||
                    status_o == isa_pkg::ST_POP_EMPTY) |-> !top_valid_o)
    else $error("empty-stack error with a valid top");

  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == isa_pkg::ST_DIV_ZERO |->
      top_valid_o && top_value_o == 32'd0)
    else $error("divide-by-zero error without a zero top");

  a_full_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == isa_pkg::ST_PUSH_FULL |-> top_valid_o)
    else $error("full-stack error with an empty stack");

endmodule

bind integer_stack_alu isa_checker u_isa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .top_value_o  (top_value_o),
  .top_valid_o  (top_valid_o),
  .status_o     (status_o)
);

`default_nettype wire
